// ===== hw/rtl/bit_slice_corner_turner_defines.svh =====
// Assertion macros for the checker file of the corner turner.
`ifndef BIT_SLICE_CORNER_TURNER_DEFINES_SVH
`define BIT_SLICE_CORNER_TURNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BSCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BSCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bsct_pkg.sv =====
// Constants and types shared by the corner turner modules.
package bsct_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic PHASE_LOAD  = 1'b0;
    localparam logic PHASE_DRAIN = 1'b1;

    typedef struct packed {
        logic             load;
        logic             drain;
        logic [CNT_W-1:0] plane;
        logic             last;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/bsct_cell.sv =====
// One cell of the chain: holds one row, takes the next row from its neighbour
// while loading and shifts its row out MSB first while draining.
module bsct_cell
    import bsct_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [WIDTH-1:0] row_in,
    output logic [WIDTH-1:0] row_out
);

    logic [WIDTH-1:0] row_reg;
    logic [WIDTH-1:0] row_next;

    always_comb
    begin
        row_next = row_reg;
        if (ctl.load)
        begin
            row_next = row_in;
        end
        else if (ctl.drain)
        begin
            row_next = {row_reg[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign row_out = row_reg;

endmodule

// ===== hw/rtl/bsct_ctrl.sv =====
// Sequencer: counts rows in, then bit planes out, and steers the cell chain.
module bsct_ctrl
    import bsct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_space,
    output logic      in_ready,
    output cell_ctl_t ctl
);

    logic             phase_reg;
    logic             phase_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] plane_reg;
    logic [CNT_W-1:0] plane_next;
    logic             load;
    logic             drain;

    assign in_ready = (phase_reg == PHASE_LOAD);
    assign load     = in_valid && in_ready;
    assign drain    = (phase_reg == PHASE_DRAIN) && out_space;

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        plane_next = plane_reg;
        if (load)
        begin
            if (fill_reg == CNT_W'(WIDTH - 1))
            begin
                // block full: start shifting planes out
                fill_next  = '0;
                plane_next = '0;
                phase_next = PHASE_DRAIN;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (drain)
        begin
            if (plane_reg == CNT_W'(WIDTH - 1))
            begin
                plane_next = '0;
                phase_next = PHASE_LOAD;
            end
            else
            begin
                plane_next = plane_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_LOAD;
            fill_reg  <= '0;
            plane_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            plane_reg <= plane_next;
        end
    end

    assign ctl.load  = load;
    assign ctl.drain = drain;
    assign ctl.plane = plane_reg;
    assign ctl.last  = (plane_reg == CNT_W'(WIDTH - 1));

endmodule

// ===== hw/rtl/bit_slice_corner_turner.sv =====
// Once the closing item of a block is accepted the sequencer enters its drain phase, and
// the output register takes the first slice when it has space. WIDTH items load, then WIDTH
// slices leave, one per cycle unless the output stalls; the single row chain serves both phases.
// in_ready is low while the chain shifts planes out; the last slice may wait in the
// output register while the next block loads.
// Reset clears the row and plane counters and the output valid; row contents are not reset.
module bit_slice_corner_turner
    import bsct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] slice_word,
    output logic [5:0]  slice_index,
    output logic        last_slice
);

    cell_ctl_t        ctl;
    logic             out_space;
    logic [WIDTH-1:0] rows [WIDTH];
    logic [WIDTH-1:0] plane_bits;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      slice_word_reg;
    logic [5:0]       slice_index_reg;
    logic             last_slice_reg;

    assign out_space = !out_valid_reg || out_ready;

    bsct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_space (out_space),
        .in_ready  (in_ready),
        .ctl       (ctl)
    );

    // new rows enter at the far end; after WIDTH loads the first row sits in cell 0
    for (genvar c = 0; c < WIDTH; c++)
    begin : g_cell
        logic [WIDTH-1:0] feed;
        if (c == WIDTH - 1)
        begin : g_head
            assign feed = value_word[WIDTH-1:0];
        end
        else
        begin : g_link
            assign feed = rows[c+1];
        end

        bsct_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .row_in  (feed),
            .row_out (rows[c])
        );

        assign plane_bits[WIDTH-1-c] = rows[c][WIDTH-1];
    end

    assign out_valid_next = ctl.drain ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.drain)
        begin
            slice_word_reg  <= 64'(plane_bits);
            slice_index_reg <= 6'(ctl.plane);
            last_slice_reg  <= ctl.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slice_word  = slice_word_reg;
    assign slice_index = slice_index_reg;
    assign last_slice  = last_slice_reg;

endmodule

// ===== hw/rtl/bsct_checker.sv =====
// Port-level checker for the corner turner and its bind to the top level.
`include "bit_slice_corner_turner_defines.svh"

module bsct_checker
    import bsct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [63:0] value_word,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] slice_word,
    input logic [5:0]  slice_index,
    input logic        last_slice
);

    logic        in_wait;
    logic        out_wait;
    logic        mid_take;
    logic        mid_shown;
    logic        last_shown;
    logic [70:0] out_pay;
    logic [5:0]  last_index;
    logic [6:0]  valid_index;
    logic [6:0]  index_step;

    assign in_wait     = in_valid && !in_ready;
    assign out_wait    = out_valid && !out_ready;
    assign mid_take    = out_valid && out_ready && !last_slice;
    assign mid_shown   = out_valid && !last_slice;
    assign last_shown  = out_valid && last_slice;
    assign out_pay     = {slice_word, slice_index, last_slice};
    assign last_index  = 6'(WIDTH - 1);
    assign valid_index = {out_valid, slice_index};
    assign index_step  = {1'b1, slice_index + 6'd1};

    `BSCT_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(value_word), "waiting item changed")
    `BSCT_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_pay), "stalled slice changed")
    `BSCT_ASSERT_NOW(a_last_index, last_shown, slice_index == last_index, "last flag off plane")
    `BSCT_ASSERT_NEXT(a_plane_step, mid_take, valid_index == $past(index_step), "planes skipped")
    `BSCT_ASSERT_NOW(a_no_load_mid_block, mid_shown, !in_ready, "input taken while draining")

endmodule

bind bit_slice_corner_turner bsct_checker u_bsct_checker (.*);
